### src/tle_pkg.sv
// Shared types and constants for the terminal line editor.
// No dependencies; every other file except tle_ifs imports this package.
`default_nettype none

package tle_pkg;

    // Character codes used by the editor
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_RUB   = 8'd127;

    // Prompt string length
    localparam int PROMPT_LEN = 5;

    // Configuration register indexes
    localparam logic [2:0] REG_TERMINAL_MODE = 3'd0;
    localparam logic [2:0] REG_PROMPT_ENABLE = 3'd1;
    localparam logic [2:0] REG_KEY_LEFT      = 3'd2;
    localparam logic [2:0] REG_KEY_RIGHT     = 3'd3;
    localparam logic [2:0] REG_KEY_END       = 3'd4;
    localparam logic [2:0] REG_KEY_RECALL    = 3'd5;
    localparam logic [2:0] REG_KEY_BACKSPACE = 3'd6;
    localparam logic [2:0] REG_KEY_DELETE    = 3'd7;

    // Editing key codes
    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] jump_end;
        logic [7:0] recall;
        logic [7:0] backspace;
        logic [7:0] del;
    } key_set_t;

    // Key matches of one byte, in priority order
    typedef struct packed {
        logic backspace;
        logic del;
        logic left;
        logic right;
        logic jump_end;
        logic recall;
    } key_hit_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic       raw;
        logic       cr;
        key_hit_t   hit;
        logic [7:0] data;
    } cmd_t;

    // Prompt text "YOU: "
    function automatic logic [7:0] prompt_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'd89;
                3'd1:    c = 8'd79;
                3'd2:    c = 8'd85;
                3'd3:    c = 8'd58;
                default: c = 8'd32;
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

### src/tle_ifs.sv
// Stream interfaces for the received-byte and result channels.
// Depends on nothing.
`default_nettype none

interface tle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tle_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_kind, output out_byte, output out_last,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input out_last,
                  output ready);
endinterface

`default_nettype wire

### src/tle_front.sv
// Front end: classifies received bytes against the key codes and queues them.
// Depends on tle_pkg and tle_in_if.
`default_nettype none

module tle_front
    import tle_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tle_in_if.sink        in_ch,
    input  wire key_set_t keys,
    input  wire logic     terminal_mode,
    output logic          cmd_valid,
    output cmd_t          cmd,
    input  wire logic     cmd_ready
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cls;
    logic       push;
    logic       pop;

    // Classify the incoming byte
    always_comb
    begin
        cls.raw           = ~terminal_mode;
        cls.cr            = (in_ch.rx_byte == CH_CR);
        cls.hit.backspace = (in_ch.rx_byte == keys.backspace);
        cls.hit.del       = (in_ch.rx_byte == keys.del);
        cls.hit.left      = (in_ch.rx_byte == keys.left);
        cls.hit.right     = (in_ch.rx_byte == keys.right);
        cls.hit.jump_end  = (in_ch.rx_byte == keys.jump_end);
        cls.hit.recall    = (in_ch.rx_byte == keys.recall);
        cls.data          = in_ch.rx_byte;
    end

    assign in_ch.ready = (count_reg != 2'd2);
    assign cmd_valid   = (count_reg != 2'd0);
    assign cmd         = queue_reg[rd_ptr_reg];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = cmd_valid && cmd_ready;

    // Two-entry queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### src/tle_back.sv
// Back end: sequencer that edits the line, keeps the recall copy and emits results.
// Depends on tle_pkg and tle_out_if.
`default_nettype none

module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_LEN = 20,
    localparam int AW = $clog2(LINE_LEN),
    localparam int IW = $clog2(LINE_LEN + 1)
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_ready,
    input  wire logic prompt_enable,
    tle_out_if.source out_ch
);

    localparam logic [IW-1:0] LAST  = IW'(LINE_LEN - 1);
    localparam logic [IW-1:0] LASTM = IW'(LINE_LEN - 2);
    localparam logic [IW-1:0] LEN   = IW'(LINE_LEN);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_PROMPT   = 14'b00000000000010,
        S_DISPATCH = 14'b00000000000100,
        S_SHIFT    = 14'b00000000001000,
        S_SH127    = 14'b00000000010000,
        S_BACK     = 14'b00000000100000,
        S_SCAN     = 14'b00000001000000,
        S_END      = 14'b00000010000000,
        S_RSPACE   = 14'b00000100000000,
        S_RDEL     = 14'b00001000000000,
        S_RCOPY    = 14'b00010000000000,
        S_CLAMP    = 14'b00100000000000,
        S_FINISH   = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t        state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] start_reg, start_next;
    logic [IW-1:0] n_reg, n_next;
    logic          zflag_reg, zflag_next;
    logic          pending_reg, pending_next;
    logic          hold_valid_reg, hold_valid_next;
    logic          hold_kind_reg;
    logic [7:0]    hold_byte_reg;
    logic          out_valid_reg;
    logic          out_kind_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic [7:0]    line_reg [LINE_LEN];
    logic [7:0]    recall_reg [LINE_LEN];

    logic          can_push;
    logic          step;
    logic          emit_en;
    logic          emit_kind;
    logic [7:0]    emit_byte;
    logic          push_en;
    logic          push_last;
    logic [AW-1:0] line_raddr;
    logic [7:0]    line_rdata;
    logic [AW-1:0] rec_raddr;
    logic [7:0]    rec_rdata;
    logic          line_we;
    logic [AW-1:0] line_waddr;
    logic [7:0]    line_wdata;
    logic          rec_we;
    logic [7:0]    rec_wdata;
    logic [IW-1:0] ip1;
    logic [7:0]    fin_val;

    assign can_push  = !out_valid_reg || out_ch.ready;
    assign step      = !(hold_valid_reg && !can_push);
    assign cmd_ready = (state_reg == S_IDLE);
    assign ip1       = i_reg + IW'(1);

    // Read port address selection
    always_comb
    begin
        unique case (state_reg)
            S_SHIFT:          line_raddr = ip1[AW-1:0];
            S_SCAN, S_FINISH: line_raddr = k_reg[AW-1:0];
            default:          line_raddr = cursor_reg[AW-1:0];
        endcase
        rec_raddr = (state_reg == S_RCOPY) ? k_reg[AW-1:0] : '0;
    end

    assign line_rdata = line_reg[line_raddr];
    assign rec_rdata  = recall_reg[rec_raddr];
    assign fin_val    = (k_reg < cursor_reg) ? line_rdata : 8'd0;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cursor_next  = cursor_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        start_next   = start_reg;
        n_next       = n_reg;
        zflag_next   = zflag_reg;
        pending_next = pending_reg;
        emit_en      = 1'b0;
        emit_kind    = 1'b0;
        emit_byte    = 8'd0;
        line_we      = 1'b0;
        line_waddr   = cursor_reg[AW-1:0];
        line_wdata   = 8'd0;
        rec_we       = 1'b0;
        rec_wdata    = 8'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    pending_next = 1'b0;
                    k_next       = '0;
                    if (pending_reg && !cmd.raw && prompt_enable)
                    begin
                        state_next = S_PROMPT;
                    end
                    else
                    begin
                        state_next = S_DISPATCH;
                    end
                end
            end

            S_PROMPT:
            begin
                emit_en   = 1'b1;
                emit_byte = prompt_char(k_reg[2:0]);
                k_next    = k_reg + IW'(1);
                if (k_reg == IW'(PROMPT_LEN - 1))
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                k_next     = '0;
                zflag_next = 1'b0;
                state_next = S_CLAMP;
                if (cmd_reg.raw)
                begin
                    line_we     = 1'b1;
                    line_wdata  = cmd_reg.data;
                    cursor_next = cursor_reg + IW'(1);
                    state_next  = (cursor_reg + IW'(1) >= LAST) ? S_FINISH : S_DONE;
                end
                else if (cmd_reg.cr)
                begin
                    state_next = S_FINISH;
                end
                else if (cmd_reg.hit == '0)
                begin
                    line_we     = 1'b1;
                    line_wdata  = cmd_reg.data;
                    emit_en     = 1'b1;
                    emit_byte   = cmd_reg.data;
                    cursor_next = cursor_reg + IW'(1);
                end
                else if (cmd_reg.hit.backspace && cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - IW'(1);
                    emit_en     = 1'b1;
                    emit_byte   = CH_BS;
                    i_next      = cursor_reg - IW'(1);
                    start_next  = cursor_reg - IW'(1);
                    state_next  = S_SHIFT;
                end
                else if (cmd_reg.hit.del && cursor_reg != LAST)
                begin
                    i_next     = cursor_reg;
                    start_next = cursor_reg;
                    state_next = S_SHIFT;
                end
                else if (cmd_reg.hit.left && cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - IW'(1);
                    emit_en     = 1'b1;
                    emit_byte   = CH_BS;
                end
                else if (cmd_reg.hit.right && cursor_reg < LAST && line_rdata != 8'd0)
                begin
                    emit_en     = 1'b1;
                    emit_byte   = line_rdata;
                    cursor_next = cursor_reg + IW'(1);
                end
                else if (cmd_reg.hit.jump_end)
                begin
                    state_next = S_SCAN;
                end
                else if (cmd_reg.hit.recall && rec_rdata != 8'd0)
                begin
                    state_next = S_RSPACE;
                end
            end

            // Shift the tail left by one and repaint it
            S_SHIFT:
            begin
                if (ip1 < LEN)
                begin
                    line_we    = 1'b1;
                    line_waddr = i_reg[AW-1:0];
                    emit_en    = 1'b1;
                    if (line_rdata != 8'd0)
                    begin
                        line_wdata = line_rdata;
                        emit_byte  = line_rdata;
                        i_next     = ip1;
                    end
                    else
                    begin
                        emit_byte  = CH_SPACE;
                        state_next = S_SH127;
                    end
                end
                else
                begin
                    state_next = S_BACK;
                end
            end

            S_SH127:
            begin
                emit_en    = 1'b1;
                emit_byte  = CH_RUB;
                state_next = S_BACK;
            end

            // Walk the terminal cursor back to the edit point
            S_BACK:
            begin
                if (i_reg > start_reg)
                begin
                    emit_en   = 1'b1;
                    emit_byte = CH_BS;
                    i_next    = i_reg - IW'(1);
                end
                else
                begin
                    state_next = S_CLAMP;
                end
            end

            // Measure text length for jump to end
            S_SCAN:
            begin
                if (k_reg < LEN && line_rdata != 8'd0)
                begin
                    k_next = k_reg + IW'(1);
                end
                else if (k_reg == '0)
                begin
                    state_next = (cmd_reg.hit.recall && rec_rdata != 8'd0) ? S_RSPACE
                                                                            : S_CLAMP;
                end
                else
                begin
                    n_next     = (k_reg > LAST) ? LAST : k_reg;
                    state_next = S_END;
                end
            end

            S_END:
            begin
                if (cursor_reg < n_reg)
                begin
                    emit_en     = 1'b1;
                    emit_byte   = line_rdata;
                    cursor_next = cursor_reg + IW'(1);
                end
                else
                begin
                    state_next = S_CLAMP;
                end
            end

            // Recall: blank the rest of the line on screen
            S_RSPACE:
            begin
                if (cursor_reg < LAST)
                begin
                    emit_en     = 1'b1;
                    emit_byte   = CH_SPACE;
                    cursor_next = cursor_reg + IW'(1);
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_RDEL;
                end
            end

            S_RDEL:
            begin
                emit_en   = 1'b1;
                emit_byte = CH_RUB;
                k_next    = k_reg + IW'(1);
                if (k_reg == LASTM)
                begin
                    k_next     = '0;
                    zflag_next = 1'b0;
                    state_next = S_RCOPY;
                end
            end

            // Recall: copy text into the line and echo it
            S_RCOPY:
            begin
                line_we    = 1'b1;
                line_waddr = k_reg[AW-1:0];
                if (!zflag_reg && rec_rdata != 8'd0)
                begin
                    emit_en    = 1'b1;
                    emit_byte  = rec_rdata;
                    line_wdata = rec_rdata;
                end
                else
                begin
                    zflag_next = 1'b1;
                    if (!zflag_reg)
                    begin
                        n_next = k_reg;
                    end
                end
                if (k_reg == LAST)
                begin
                    if (zflag_reg)
                    begin
                        cursor_next = n_reg;
                    end
                    else if (rec_rdata == 8'd0)
                    begin
                        cursor_next = k_reg;
                    end
                    else
                    begin
                        cursor_next = LAST;
                    end
                    state_next = S_CLAMP;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            S_CLAMP:
            begin
                if (cursor_reg >= LAST)
                begin
                    cursor_next = LASTM;
                    emit_en     = 1'b1;
                    emit_byte   = CH_BS;
                end
                state_next = S_DONE;
            end

            // Deliver the line, save it for recall and clear it
            S_FINISH:
            begin
                emit_en    = 1'b1;
                emit_kind  = 1'b1;
                emit_byte  = fin_val;
                line_we    = 1'b1;
                line_waddr = k_reg[AW-1:0];
                rec_we     = 1'b1;
                rec_wdata  = (!zflag_reg) ? fin_val : 8'd0;
                if (fin_val == 8'd0)
                begin
                    zflag_next = 1'b1;
                end
                if (k_reg == LAST)
                begin
                    cursor_next  = '0;
                    pending_next = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result hand-off: the held result goes out once the next one or the end is known
    assign push_en   = step && hold_valid_reg && (emit_en || state_reg == S_DONE);
    assign push_last = (state_reg == S_DONE);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (step && emit_en)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step && state_reg == S_DONE)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= '0;
            pending_reg    <= 1'b1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
            start_reg      <= '0;
            n_reg          <= '0;
            zflag_reg      <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                state_reg   <= state_next;
                cursor_reg  <= cursor_next;
                pending_reg <= pending_next;
                k_reg       <= k_next;
                i_reg       <= i_next;
                start_reg   <= start_next;
                n_reg       <= n_next;
                zflag_reg   <= zflag_next;
            end
            hold_valid_reg <= hold_valid_next;
            if (push_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cmd_reg <= cmd_next;
        end
        if (step && emit_en)
        begin
            hold_kind_reg <= emit_kind;
            hold_byte_reg <= emit_byte;
        end
        if (push_en)
        begin
            out_kind_reg <= hold_kind_reg;
            out_byte_reg <= hold_byte_reg;
            out_last_reg <= push_last;
        end
    end

    // Line and recall stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < LINE_LEN; e++)
            begin
                line_reg[e]   <= 8'd0;
                recall_reg[e] <= 8'd0;
            end
        end
        else if (step)
        begin
            if (line_we)
            begin
                line_reg[line_waddr] <= line_wdata;
            end
            if (rec_we)
            begin
                recall_reg[k_reg[AW-1:0]] <= rec_wdata;
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_kind = out_kind_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    // Between items no result is held back and the cursor sits left of the last cell
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!hold_valid_reg && cursor_reg <= LASTM))
        else $error("idle with held result or cursor out of range");

    // A finished line always rearms the prompt
    a_finish_prompt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && step && k_reg == LAST) |=>
            (pending_reg && cursor_reg == '0))
        else $error("line finish did not rearm prompt");

    // The output register is never overwritten while a result waits
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> can_push)
        else $error("result pushed into a full output stage");

endmodule

`default_nettype wire

### src/terminal_line_editor.sv
// Top level of the terminal line editor: configuration registers, front and back.
// Depends on tle_pkg, tle_ifs, tle_front and tle_back.
//
// Each received byte is classified by the front end and queued (two entries), then
// executed by a back-end sequencer that produces at most one result per cycle. The last
// result of each item carries out_last. Results wait in a hold register and an output
// register, so the back end keeps going while the sink stalls until both are full, and
// the front keeps taking bytes while the back end works until its queue is full.
`default_nettype none

module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_LEN = 20
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    tle_in_if.sink          in_ch,
    tle_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    logic     terminal_mode_reg;
    logic     prompt_enable_reg;
    key_set_t keys_reg;
    logic     cmd_valid;
    cmd_t     cmd;
    logic     cmd_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminal_mode_reg  <= 1'b1;
            prompt_enable_reg  <= 1'b1;
            keys_reg.left      <= 8'd68;
            keys_reg.right     <= 8'd67;
            keys_reg.jump_end  <= 8'd66;
            keys_reg.recall    <= 8'd65;
            keys_reg.backspace <= 8'd127;
            keys_reg.del       <= 8'd126;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TERMINAL_MODE: terminal_mode_reg  <= cfg_data[0];
                REG_PROMPT_ENABLE: prompt_enable_reg  <= cfg_data[0];
                REG_KEY_LEFT:      keys_reg.left      <= cfg_data;
                REG_KEY_RIGHT:     keys_reg.right     <= cfg_data;
                REG_KEY_END:       keys_reg.jump_end  <= cfg_data;
                REG_KEY_RECALL:    keys_reg.recall    <= cfg_data;
                REG_KEY_BACKSPACE: keys_reg.backspace <= cfg_data;
                REG_KEY_DELETE:    keys_reg.del       <= cfg_data;
                default:           keys_reg           <= keys_reg;
            endcase
        end
    end

    tle_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .keys          (keys_reg),
        .terminal_mode (terminal_mode_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_ready     (cmd_ready)
    );

    tle_back #(
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_ready     (cmd_ready),
        .prompt_enable (prompt_enable_reg),
        .out_ch        (out_ch)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for terminal_line_editor: directed table, then random editing.
// Depends on tle_pkg, tle_ifs and the terminal_line_editor RTL.
`timescale 1ns / 1ps

module tb_top;
    import tle_pkg::*;

    localparam int LINE_LEN = 20;
    localparam int MAX_OUT  = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } echo_t;

    // Directed row: byte to send; typed count and last byte where known (count < 0: none)
    typedef struct {
        logic [7:0] b;
        int         n;
        logic [7:0] last_b;
    } row_t;

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    tle_in_if  in_ch();
    tle_out_if out_ch();

    terminal_line_editor #(.LINE_LEN(LINE_LEN)) uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [7:0] line_buf [LINE_LEN];
    logic [7:0] saved_line [LINE_LEN];
    int         cur;
    bit         prompt_due;
    logic       term_on, prompt_on;
    key_set_t   keys;

    echo_t exp_q [$];
    int    n_new;
    int    errors;
    bit    calm;
    int    quiet_cycles;

    // Clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    task automatic report(input string what);
        errors++;
        $display("ERROR t=%0t: %s", $time, what);
    endtask

    function automatic void push_echo(input logic kind, input logic [7:0] b);
        echo_t e;
        if (n_new < MAX_OUT)
        begin
            e.kind = kind;
            e.data = b;
            e.last = 1'b0;
            exp_q.push_back(e);
            n_new++;
        end
    endfunction

    function automatic int text_length(input bit use_saved);
        int n;
        n = 0;
        while (n < LINE_LEN && (use_saved ? saved_line[n] : line_buf[n]) != 8'd0)
            n++;
        return n;
    endfunction

    function automatic void deliver_line();
        int n;
        for (int k = 0; k < LINE_LEN; k++)
            push_echo(1'b1, line_buf[k]);
        n = text_length(1'b0);
        for (int k = 0; k < LINE_LEN; k++)
        begin
            saved_line[k] = (k < n) ? line_buf[k] : 8'd0;
            line_buf[k] = 8'd0;
        end
        cur = 0;
        prompt_due = 1'b1;
    endfunction

    // Close the gap at the cursor and redraw the tail of the line
    function automatic void close_gap();
        int i;
        int start;
        i = cur;
        start = cur;
        for (; i + 1 < LINE_LEN; i++)
        begin
            if (line_buf[i + 1] != 8'd0)
            begin
                line_buf[i] = line_buf[i + 1];
                push_echo(1'b0, line_buf[i]);
            end
            else
            begin
                line_buf[i] = 8'd0;
                push_echo(1'b0, CH_SPACE);
                push_echo(1'b0, CH_RUB);
                break;
            end
        end
        for (; i > start; i--)
            push_echo(1'b0, CH_BS);
    endfunction

    function automatic void edit_line(input logic [7:0] c);
        bit is_key;
        int n;
        is_key = (c == keys.left || c == keys.right || c == keys.jump_end ||
                  c == keys.recall || c == keys.backspace || c == keys.del);
        if (c == CH_CR)
        begin
            for (int k = cur; k < LINE_LEN; k++)
                line_buf[k] = 8'd0;
            deliver_line();
            return;
        end
        if (!is_key)
        begin
            line_buf[cur] = c;
            push_echo(1'b0, c);
            cur++;
        end
        else if (c == keys.backspace && cur > 0)
        begin
            cur--;
            push_echo(1'b0, CH_BS);
            close_gap();
        end
        else if (c == keys.del && cur != LINE_LEN - 1)
            close_gap();
        else if (c == keys.left && cur > 0)
        begin
            cur--;
            push_echo(1'b0, CH_BS);
        end
        else if (c == keys.right && cur < LINE_LEN - 1 && line_buf[cur] != 8'd0)
        begin
            push_echo(1'b0, line_buf[cur]);
            cur++;
        end
        else if (c == keys.jump_end && text_length(1'b0) > 0)
        begin
            n = text_length(1'b0);
            if (n > LINE_LEN - 1)
                n = LINE_LEN - 1;
            for (; cur < n; cur++)
                push_echo(1'b0, line_buf[cur]);
        end
        else if (c == keys.recall && text_length(1'b1) > 0)
        begin
            for (; cur < LINE_LEN - 1; cur++)
                push_echo(1'b0, CH_SPACE);
            for (int k = LINE_LEN - 1; k > 0; k--)
                push_echo(1'b0, CH_RUB);
            n = text_length(1'b1);
            for (int k = 0; k < n; k++)
                push_echo(1'b0, saved_line[k]);
            for (int k = 0; k < LINE_LEN; k++)
                line_buf[k] = (k < n) ? saved_line[k] : 8'd0;
            cur = (n > LINE_LEN - 1) ? LINE_LEN - 1 : n;
        end
        // Right end: step back one
        if (cur >= LINE_LEN - 1)
        begin
            cur = LINE_LEN - 2;
            push_echo(1'b0, CH_BS);
        end
    endfunction

    // Expected results of one accepted byte, appended to exp_q; returns their count
    function automatic int predict_echo(input logic [7:0] c);
        n_new = 0;
        if (cur > LINE_LEN - 2)
            cur = LINE_LEN - 2;
        if (prompt_due)
        begin
            prompt_due = 1'b0;
            if (term_on && prompt_on)
                for (int k = 0; k < PROMPT_LEN; k++)
                    push_echo(1'b0, prompt_char(k[2:0]));
        end
        if (term_on)
            edit_line(c);
        else
        begin
            line_buf[cur] = c;
            cur++;
            if (cur >= LINE_LEN - 1)
                deliver_line();
        end
        if (n_new > 0)
            exp_q[$].last = 1'b1;
        return n_new;
    endfunction

    // Result side: random stalls and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
            if (out_ch.valid && out_ch.ready)
            begin
                if (exp_q.size() == 0)
                    report($sformatf("unexpected result byte %0d", out_ch.out_byte));
                else
                begin
                    if (out_ch.out_kind !== exp_q[0].kind)
                        report($sformatf("out_kind %b, expected %b",
                                         out_ch.out_kind, exp_q[0].kind));
                    if (out_ch.out_byte !== exp_q[0].data)
                        report($sformatf("out_byte %0d, expected %0d",
                                         out_ch.out_byte, exp_q[0].data));
                    if (out_ch.out_last !== exp_q[0].last)
                        report($sformatf("out_last %b, expected %b",
                                         out_ch.out_last, exp_q[0].last));
                    void'(exp_q.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one byte and predict its results
    task automatic send_byte(input logic [7:0] b, output int n);
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        n = predict_echo(b);
        if (!calm && $urandom_range(99) < 25)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Register write once the block has drained
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        in_ch.valid <= 1'b0;
        wait (exp_q.size() == 0);
        repeat (80) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TERMINAL_MODE: term_on = val[0];
            REG_PROMPT_ENABLE: prompt_on = val[0];
            REG_KEY_LEFT:      keys.left = val;
            REG_KEY_RIGHT:     keys.right = val;
            REG_KEY_END:       keys.jump_end = val;
            REG_KEY_RECALL:    keys.recall = val;
            REG_KEY_BACKSPACE: keys.backspace = val;
            default:           keys.del = val;
        endcase
    endtask

    // Mostly text and keys, some returns, some arbitrary bytes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 8'($urandom_range(97, 122));
        else if (r < 70)
        begin
            case ($urandom_range(5))
                0: return keys.left;
                1: return keys.right;
                2: return keys.jump_end;
                3: return keys.recall;
                4: return keys.backspace;
                default: return keys.del;
            endcase
        end
        else if (r < 80)
            return CH_CR;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_run(input int count);
        int n;
        for (int k = 0; k < count; k++)
        begin
            calm = (k >= count / 3 && k < count / 3 + 15);
            send_byte(pick_byte(), n);
        end
        calm = 1'b0;
    endtask

    row_t rows [$];
    int   got;

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.rx_byte = 8'd0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TERMINAL_MODE;
        cfg_data = 8'd0;
        errors = 0;
        calm = 1'b0;
        quiet_cycles = 0;
        for (int k = 0; k < LINE_LEN; k++)
        begin
            line_buf[k] = 8'd0;
            saved_line[k] = 8'd0;
        end
        cur = 0;
        prompt_due = 1'b1;
        term_on = 1'b1;
        prompt_on = 1'b1;
        keys = '{left: 8'd68, right: 8'd67, jump_end: 8'd66, recall: 8'd65,
                 backspace: 8'd127, del: 8'd126};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: prompt, extremes, every key, return, recall, right end
        rows = '{
            '{8'd97, 6, 8'd97}, '{8'd255, 1, 8'd255}, '{8'd0, 1, 8'd0},
            '{8'd68, 1, CH_BS}, '{8'd68, 1, CH_BS}, '{8'd67, -1, 0}, '{8'd66, -1, 0},
            '{8'd68, 1, CH_BS}, '{8'd127, -1, 0}, '{8'd126, -1, 0}, '{8'd13, 20, 8'd0},
            '{8'd127, 5, CH_SPACE}, '{8'd65, -1, 0}, '{8'd13, -1, 0}, '{8'd120, -1, 0},
            '{8'd121, -1, 0}, '{8'd122, -1, 0}, '{8'd123, -1, 0}, '{8'd124, -1, 0},
            '{8'd125, -1, 0}, '{8'd33, -1, 0}, '{8'd34, -1, 0}, '{8'd66, -1, 0},
            '{8'd13, -1, 0}
        };
        foreach (rows[i])
        begin
            send_byte(rows[i].b, got);
            if (rows[i].n >= 0 && (got != rows[i].n ||
                (got > 0 && exp_q[$].data != rows[i].last_b)))
                report($sformatf("directed row %0d predicts %0d results", i, got));
        end

        // Random phases across register settings
        random_run(30);
        write_reg(REG_PROMPT_ENABLE, 8'd0);
        random_run(25);
        write_reg(REG_TERMINAL_MODE, 8'd0);
        random_run(30);
        write_reg(REG_TERMINAL_MODE, 8'd1);
        write_reg(REG_PROMPT_ENABLE, 8'd1);
        write_reg(REG_KEY_LEFT, 8'd0);
        write_reg(REG_KEY_RIGHT, 8'd255);
        write_reg(REG_KEY_END, 8'd1);
        write_reg(REG_KEY_RECALL, 8'd254);
        write_reg(REG_KEY_BACKSPACE, 8'd8);
        write_reg(REG_KEY_DELETE, 8'd13);
        random_run(40);
        write_reg(REG_KEY_DELETE, 8'd126);
        random_run(20);

        in_ch.valid <= 1'b0;
        wait (exp_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
